[src/pmh_pkg.sv]
// Shared constants, payload types and inter-cell buses for the max-height pipeline.
package pmh_pkg;

   localparam int TERMS       = 10;
   localparam int SPEED_W     = 24;
   localparam int ANGLE_W     = 20;
   localparam int HEIGHT_W    = 40;
   localparam int GRAV_W      = 16;
   localparam int TERM_W      = 36;
   localparam int X2_W        = 35;
   localparam int RECIP_W     = 28;
   localparam int FACT_W      = 33;
   localparam int FRAC_W      = 30;
   localparam int ANGLE_LIMIT = 262144;
   localparam int GRAV_RESET  = 2511;
   localparam int PADDR_W     = 3;
   localparam int PDATA_W     = 32;
   localparam int DIV_STEPS   = HEIGHT_W;

   // register index, taken from paddr[2]
   localparam logic CSR_GRAVITY = 1'b0;

   typedef logic [RECIP_W-1:0] recip_type;

   // floor(2^30 / ((2n)(2n+1))), n = 1..15; entry 0 unused
   localparam recip_type RECIP_TABLE [16] = '{
      28'd0,        28'd178956970, 28'd53687091, 28'd25565281,
      28'd14913080, 28'd9761289,   28'd6882960,  28'd5113056,
      28'd3947580,  28'd3139595,   28'd2556528,  28'd2122019,
      28'd1789569,  28'd1529546,   28'd1322342,  28'd1154561
   };

   typedef struct packed {
      logic [SPEED_W-1:0]        speed;
      logic signed [ANGLE_W-1:0] angle;
   } req_type;

   typedef struct packed {
      logic [HEIGHT_W-1:0] height;
      logic                overflow;
   } rsp_type;

   typedef struct packed {
      logic                     valid;
      logic [SPEED_W-1:0]       speed;
      logic [X2_W-1:0]          x2;
      logic signed [TERM_W-1:0] term;
      logic signed [TERM_W-1:0] sum;
   } term_bus_type;

   typedef struct packed {
      logic                valid;
      logic                ovf;
      logic [GRAV_W-1:0]   rem;
      logic [HEIGHT_W-1:0] quo;
   } div_bus_type;

endpackage

[src/pmh_taylor_cell.sv]
// One Taylor series cell: forms the next term and adds it to the running sine sum.
module pmh_taylor_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  pmh_pkg::recip_type    recip,
   input  pmh_pkg::term_bus_type in_bus,
   output pmh_pkg::term_bus_type out_bus
);
   import pmh_pkg::*;

   term_bus_type            a_ff;
   logic [FACT_W-1:0]       fact_ff;
   logic [FACT_W-1:0]       fact_in;
   logic [X2_W+RECIP_W-1:0] fprod;

   term_bus_type               b_ff;
   term_bus_type               b_in;
   logic [TERM_W-1:0]          mag;
   logic [TERM_W+FACT_W-1:0]   tprod;
   logic signed [TERM_W-1:0]   tmag;

   // factor = x^2 / ((2n)(2n+1)) in Q30
   assign fprod   = in_bus.x2 * recip;
   assign fact_in = fprod[FACT_W+FRAC_W-1:FRAC_W];

   // term_n = -(term_{n-1} * factor), truncated toward zero
   always_comb begin
      mag   = a_ff.term[TERM_W-1] ? TERM_W'(-a_ff.term) : TERM_W'(a_ff.term);
      tprod = mag * fact_ff;
      tmag  = tprod[TERM_W+FRAC_W-1:FRAC_W];
      b_in  = a_ff;
      b_in.term = a_ff.term[TERM_W-1] ? tmag : -tmag;
      b_in.sum  = a_ff.sum + b_in.term;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
         b_ff.valid <= 1'b0;
      end else if (enable) begin
         a_ff.valid <= in_bus.valid;
         b_ff.valid <= a_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_ff.speed <= in_bus.speed;
         a_ff.x2    <= in_bus.x2;
         a_ff.term  <= in_bus.term;
         a_ff.sum   <= in_bus.sum;
         fact_ff    <= fact_in;
         b_ff.speed <= b_in.speed;
         b_ff.x2    <= b_in.x2;
         b_ff.term  <= b_in.term;
         b_ff.sum   <= b_in.sum;
      end
   end

   assign out_bus = b_ff;

endmodule

[src/pmh_div_cell.sv]
// One restoring-division cell: produces one quotient bit per item.
module pmh_div_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  logic [pmh_pkg::GRAV_W-1:0] divisor,
   input  pmh_pkg::div_bus_type       in_bus,
   output pmh_pkg::div_bus_type       out_bus
);
   import pmh_pkg::*;

   div_bus_type       cell_ff;
   div_bus_type       cell_in;
   logic [GRAV_W:0]   r2;
   logic              ge;

   always_comb begin
      r2      = {in_bus.rem, in_bus.quo[HEIGHT_W-1]};
      ge      = r2 >= {1'b0, divisor};
      cell_in = in_bus;
      cell_in.rem = ge ? GRAV_W'(r2 - {1'b0, divisor}) : r2[GRAV_W-1:0];
      cell_in.quo = {in_bus.quo[HEIGHT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (enable) begin
         cell_ff.valid <= cell_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cell_ff.ovf <= cell_in.ovf;
         cell_ff.rem <= cell_in.rem;
         cell_ff.quo <= cell_in.quo;
      end
   end

   assign out_bus = cell_ff;

endmodule

[src/projectile_max_height_top.sv]
// Top level of the projectile maximum-height pipeline.
// Takes one item per cycle (speed in 1/256 m/s, angle in signed Q4.16 rad) and returns
// height = speed^2 * sin^2(angle) / (2 * gravity) in 1/256 m, saturated to
// 2^40-1 with overflow set. Fully pipelined: a new item may enter every cycle.
// Items pass through the input stage, the chain of Taylor cells (two stages
// each), the squaring and product stages and the 40 one-bit divider cells.
// The whole pipeline holds only while a finished result is stalled at the output.
// Gravity (reset 2511, zero taken as 1) is written over the csr_ port at
// address 0 and must only change while no item is in flight.
module projectile_max_height_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  pmh_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output pmh_pkg::rsp_type            rsp_data,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [pmh_pkg::PADDR_W-1:0] csr_paddr,
   input  logic [pmh_pkg::PDATA_W-1:0] csr_pwdata,
   output logic [pmh_pkg::PDATA_W-1:0] csr_prdata,
   output logic                        csr_pready
);
   import pmh_pkg::*;

   localparam int NCELL = TERMS - 1;

   // ---------------- configuration ----------------
   logic [GRAV_W-1:0] gravity_ff;
   logic [GRAV_W-1:0] gravity_in;
   logic [GRAV_W-1:0] g_eff;
   logic              csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == CSR_GRAVITY);
   assign gravity_in = csr_wr ? csr_pwdata[GRAV_W-1:0] : gravity_ff;
   assign csr_prdata = (csr_paddr[2] == CSR_GRAVITY) ?
                       {{(PDATA_W-GRAV_W){1'b0}}, gravity_ff} : '0;
   assign g_eff      = (gravity_ff == '0) ? GRAV_W'(1) : gravity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff <= GRAV_W'(GRAV_RESET);
      end else begin
         gravity_ff <= gravity_in;
      end
   end

   // global advance: whole pipeline moves unless the output item is held
   logic advance;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // ---------------- input stage: clamp, x, x^2 ----------------
   logic signed [ANGLE_W-1:0] ang_c;
   logic [ANGLE_W-2:0]        ang_mag;
   logic [2*ANGLE_W-3:0]      ang_sq;
   term_bus_type              in_ff;
   term_bus_type              in_in;

   always_comb begin
      if (req_data.angle > ANGLE_W'(ANGLE_LIMIT)) begin
         ang_c = ANGLE_W'(ANGLE_LIMIT);
      end else if (req_data.angle < -ANGLE_W'(ANGLE_LIMIT)) begin
         ang_c = -ANGLE_W'(ANGLE_LIMIT);
      end else begin
         ang_c = req_data.angle;
      end
      ang_mag     = ang_c[ANGLE_W-1] ? (ANGLE_W-1)'(-ang_c) : ang_c[ANGLE_W-2:0];
      ang_sq      = ang_mag * ang_mag;
      in_in.valid = req_valid;
      in_in.speed = req_data.speed;
      in_in.x2    = ang_sq[X2_W+1:2];
      in_in.term  = {{(TERM_W-ANGLE_W-14){ang_c[ANGLE_W-1]}}, ang_c, 14'b0};
      in_in.sum   = in_in.term;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff.valid <= 1'b0;
      end else if (advance) begin
         in_ff.valid <= in_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_ff.speed <= in_in.speed;
         in_ff.x2    <= in_in.x2;
         in_ff.term  <= in_in.term;
         in_ff.sum   <= in_in.sum;
      end
   end

   // ---------------- Taylor chain ----------------
   term_bus_type tbus [NCELL+1];
   assign tbus[0] = in_ff;

   for (genvar n = 0; n < NCELL; n++) begin : g_taylor
      pmh_taylor_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .enable  (advance),
         .recip   (RECIP_TABLE[n+1]),
         .in_bus  (tbus[n]),
         .out_bus (tbus[n+1])
      );
   end

   term_bus_type tail;
   assign tail = tbus[NCELL];

   // ---------------- sine squared, speed squared ----------------
   logic [TERM_W-2:0] ms;
   logic [17:0]       mh;
   logic [16:0]       ml;
   logic              q1_valid_ff;
   logic [35:0]       pp_hh_ff;
   logic [34:0]       pp_hl_ff;
   logic [33:0]       pp_ll_ff;
   logic [47:0]       v2_ff;

   assign ms = tail.sum[TERM_W-1] ? (TERM_W-1)'(-tail.sum) : tail.sum[TERM_W-2:0];
   assign mh = ms[34:17];
   assign ml = ms[16:0];

   logic              q2_valid_ff;
   logic [69:0]       sq;
   logic [39:0]       s2_ff;
   logic [47:0]       v2b_ff;
   assign sq = (70'(pp_hh_ff) << 34) + (70'(pp_hl_ff) << 18) + 70'(pp_ll_ff);

   logic              q3_valid_ff;
   logic [67:0]       ph_ff;
   logic [67:0]       pl_ff;

   logic [87:0]       prod;
   logic [56:0]       q;
   div_bus_type       pre_ff;
   div_bus_type       pre_in;

   assign prod = (88'(ph_ff) << 20) + 88'(pl_ff);
   assign q    = prod[87:31];

   always_comb begin
      pre_in.valid = q3_valid_ff;
      pre_in.ovf   = q[56:40] >= {1'b0, g_eff};
      pre_in.rem   = q[55:40];
      pre_in.quo   = q[39:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q1_valid_ff  <= 1'b0;
         q2_valid_ff  <= 1'b0;
         q3_valid_ff  <= 1'b0;
         pre_ff.valid <= 1'b0;
      end else if (advance) begin
         q1_valid_ff  <= tail.valid;
         q2_valid_ff  <= q1_valid_ff;
         q3_valid_ff  <= q2_valid_ff;
         pre_ff.valid <= pre_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pp_hh_ff   <= mh * mh;
         pp_hl_ff   <= mh * ml;
         pp_ll_ff   <= ml * ml;
         v2_ff      <= tail.speed * tail.speed;
         s2_ff      <= sq[69:30];
         v2b_ff     <= v2_ff;
         ph_ff      <= v2b_ff * s2_ff[39:20];
         pl_ff      <= v2b_ff * s2_ff[19:0];
         pre_ff.ovf <= pre_in.ovf;
         pre_ff.rem <= pre_in.rem;
         pre_ff.quo <= pre_in.quo;
      end
   end

   // ---------------- divider chain ----------------
   div_bus_type dbus [DIV_STEPS+1];
   assign dbus[0] = pre_ff;

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      pmh_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .enable  (advance),
         .divisor (g_eff),
         .in_bus  (dbus[k]),
         .out_bus (dbus[k+1])
      );
   end

   // last divider cell is the output register
   assign rsp_valid         = dbus[DIV_STEPS].valid;
   assign rsp_data.overflow = dbus[DIV_STEPS].ovf;
   assign rsp_data.height   = dbus[DIV_STEPS].ovf ? '1 : dbus[DIV_STEPS].quo;

   // ---------------- checks ----------------
   a_ovf_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |-> (&rsp_data.height))
      else $error("overflow without saturated height");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      pre_ff.valid && !pre_ff.ovf |-> (pre_ff.rem < g_eff))
      else $error("divider start remainder not below gravity");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid && !in_ff.valid)
      else $error("pipeline not empty after reset");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(in_ff.valid) && $stable(pre_ff.valid))
      else $error("pipeline moved while output held");

endmodule
